FILE: sv/mm_pkg.sv
// Shared constants, types and helper functions for the matrix multiply core.
// Used by the sequencer, the multiply-accumulate pipeline and the top level.
// Depends on nothing.
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;
  localparam int IN_W      = 16;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = IDX_W + 1;
  localparam int PROD_W    = 35;
  localparam int MUL_W     = 2 * ELEM_BITS;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             first;
    logic             lastk;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

FILE: sv/mm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for both matrix stores. No dependencies.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mm_seq.sv
// Address sequencer that walks row, column and inner index of the product.
// Issues one store read pair per cycle with its pipeline tag. Uses mm_pkg.
module mm_seq
  import mm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              launch,
  input  logic [DIM_W-1:0]  nr,
  input  logic [DIM_W-1:0]  nk,
  input  logic [DIM_W-1:0]  nc,
  output logic              active,
  output tag_t              tag,
  output logic [ADDR_W-1:0] a_addr,
  output logic [ADDR_W-1:0] b_addr
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic             last_i;
  logic             last_j;
  logic             last_k;
  logic             zero_k;

  assign zero_k = (nk == '0);
  assign last_k = zero_k || (({1'b0, k} + DIM_W'(1)) == nk);
  assign last_j = (({1'b0, j} + DIM_W'(1)) == nc);
  assign last_i = (({1'b0, i} + DIM_W'(1)) == nr);

  assign active     = (state == S_RUN);
  assign tag.valid  = active;
  assign tag.zero   = zero_k;
  assign tag.first  = (k == '0);
  assign tag.lastk  = last_k;
  assign tag.last   = last_i && last_j;
  assign tag.row    = i;
  assign tag.col    = j;
  assign a_addr     = elem_addr(i, k);
  assign b_addr     = elem_addr(k, j);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
          if (launch && (nr != '0) && (nc != '0)) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!last_k) begin
            k <= k + IDX_W'(1);
          end else begin
            k <= '0;
            if (!last_j) begin
              j <= j + IDX_W'(1);
            end else begin
              j <= '0;
              if (!last_i) begin
                i <= i + IDX_W'(1);
              end else begin
                i     <= '0;
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/mm_mac.sv
// Multiply-accumulate pipeline fed by the two store read ports.
// Registers the product of each pair, sums over the inner index and emits results.
// Uses mm_pkg.
module mm_mac
  import mm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  tag_t                        tag_in,
  input  logic signed [ELEM_BITS-1:0] a_data,
  input  logic signed [ELEM_BITS-1:0] b_data,
  output logic                        pending,
  output logic                        strobe,
  output logic [IDX_W-1:0]            out_row,
  output logic [IDX_W-1:0]            out_col,
  output logic signed [PROD_W-1:0]    product,
  output logic                        last
);

  tag_t                     tag1;
  tag_t                     tag2;
  logic signed [MUL_W-1:0]  mul;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] acc_next;

  assign pending  = tag1.valid || tag2.valid;
  assign acc_next = (tag2.first ? PROD_W'(0) : acc) + PROD_W'(mul);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      tag1.valid <= tag_in.valid;
      tag2.valid <= tag1.valid;
      strobe     <= tag2.valid && tag2.lastk;
    end
    tag1.zero  <= tag_in.zero;
    tag1.first <= tag_in.first;
    tag1.lastk <= tag_in.lastk;
    tag1.last  <= tag_in.last;
    tag1.row   <= tag_in.row;
    tag1.col   <= tag_in.col;
    tag2.zero  <= tag1.zero;
    tag2.first <= tag1.first;
    tag2.lastk <= tag1.lastk;
    tag2.last  <= tag1.last;
    tag2.row   <= tag1.row;
    tag2.col   <= tag1.col;
    mul        <= tag1.zero ? MUL_W'(0) : a_data * b_data;
    if (tag2.valid) begin
      acc <= acc_next;
    end
    if (tag2.valid && tag2.lastk) begin
      out_row <= tag2.row;
      out_col <= tag2.col;
      product <= acc_next;
      last    <= tag2.last;
    end
  end

endmodule

FILE: sv/matrix_multiply_core.sv
// Matrix multiply core: loads A and B one element per transaction, emits A*B on go.
// After a go transaction the sequencer walks the inner index for each result, n steps
// apiece, where n is inner_dim saturated to 8 and raised to at least 1, so the spacing
// of results is set by the single read port of each store.
// Reset sets all three dimension registers to 8; the stores are not cleared.
// Results cannot be stalled by the receiver; busy falls as the final result strobes.
module matrix_multiply_core
  import mm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        which_matrix,
  input  logic [IDX_W-1:0]            row_index,
  input  logic [IDX_W-1:0]            col_index,
  input  logic signed [IN_W-1:0]      element,
  input  logic                        go,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DIM_W-1:0]            cfg_data,
  output logic                        strobe,
  output logic [IDX_W-1:0]            out_row,
  output logic [IDX_W-1:0]            out_col,
  output logic signed [PROD_W-1:0]    product,
  output logic                        last
);

  logic [DIM_W-1:0]            rows_a;
  logic [DIM_W-1:0]            inner_dim;
  logic [DIM_W-1:0]            cols_b;
  logic [DIM_W-1:0]            nr;
  logic [DIM_W-1:0]            nk;
  logic [DIM_W-1:0]            nc;
  logic                        accept;
  logic                        in_range;
  logic [ADDR_W-1:0]           waddr;
  logic signed [ELEM_BITS-1:0] wdata;
  logic                        seq_active;
  logic                        mac_pending;
  tag_t                        tag;
  logic [ADDR_W-1:0]           a_addr;
  logic [ADDR_W-1:0]           b_addr;
  logic signed [ELEM_BITS-1:0] a_data;
  logic signed [ELEM_BITS-1:0] b_data;

  assign cfg_ready = 1'b1;
  assign busy      = seq_active || mac_pending;
  assign accept    = start && !busy;
  assign nr        = clamp_dim(rows_a);
  assign nk        = clamp_dim(inner_dim);
  assign nc        = clamp_dim(cols_b);
  assign in_range  = ({1'b0, row_index} < DIM_W'(MAX_DIM)) &&
                     ({1'b0, col_index} < DIM_W'(MAX_DIM));
  assign waddr     = elem_addr(row_index, col_index);
  assign wdata     = ELEM_BITS'(element);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(8);
      inner_dim <= DIM_W'(8);
      cols_b    <= DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (accept && in_range && !which_matrix),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_addr),
    .rdata (a_data)
  );

  mm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (accept && in_range && which_matrix),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_addr),
    .rdata (b_data)
  );

  mm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .launch (accept && go),
    .nr     (nr),
    .nk     (nk),
    .nc     (nc),
    .active (seq_active),
    .tag    (tag),
    .a_addr (a_addr),
    .b_addr (b_addr)
  );

  mm_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag),
    .a_data  (a_data),
    .b_data  (b_data),
    .pending (mac_pending),
    .strobe  (strobe),
    .out_row (out_row),
    .out_col (out_col),
    .product (product),
    .last    (last)
  );

  a_strobe_needs_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without work in flight");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result strobe directly after the final element");

  a_go_starts_burst: assert property (@(posedge clk) disable iff (rst)
    (accept && go && (nr != '0) && (nc != '0)) |=> busy)
    else $error("go transaction did not start a product");

endmodule
